FILE: hdl/rgb16_brightness_scale_assert.svh
// ----------------------------------------------------------------------------
// rgb16_brightness_scale assertion macros
// Shared property forms used by the brightness scaler checks.
// ----------------------------------------------------------------------------
`ifndef RGB16_BRIGHTNESS_SCALE_ASSERT_SVH
`define RGB16_BRIGHTNESS_SCALE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RGBBS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rgb16_brightness_scale: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define RGBBS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rgb16_brightness_scale: next-cycle check failed");

`endif

FILE: hdl/rgbbs_pkg.sv
// ----------------------------------------------------------------------------
// rgbbs_pkg
// Types, constants and register indexes of the RGB16 brightness scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbbs_pkg;

  localparam int PIXEL_W   = 16;
  localparam int CHAN_W    = 8;
  localparam int POS_W     = 4;
  localparam int PAD_W     = 3;
  localparam int NUM_CHAN  = 3;
  localparam int DIV_STEPS = CHAN_W;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 8;

  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  localparam logic [CHAN_W-1:0] RST_BRIGHTNESS_NOW = 8'd255;
  localparam logic [CHAN_W-1:0] RST_BRIGHTNESS_MAX = 8'd255;
  localparam logic [POS_W-1:0]  RST_RED_POS        = 4'd11;
  localparam logic [POS_W-1:0]  RST_GREEN_POS      = 4'd5;
  localparam logic [POS_W-1:0]  RST_BLUE_POS       = 4'd0;
  localparam logic [PAD_W-1:0]  RST_RED_PAD        = 3'd3;
  localparam logic [PAD_W-1:0]  RST_GREEN_PAD      = 3'd2;
  localparam logic [PAD_W-1:0]  RST_BLUE_PAD       = 3'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BRIGHTNESS_NOW = 3'd0,
    REG_BRIGHTNESS_MAX = 3'd1,
    REG_RED_POSITION   = 3'd2,
    REG_GREEN_POSITION = 3'd3,
    REG_BLUE_POSITION  = 3'd4,
    REG_RED_PAD        = 3'd5,
    REG_GREEN_PAD      = 3'd6,
    REG_BLUE_PAD       = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [CHAN_W-1:0]                level;
    logic [CHAN_W-1:0]                max_level;
    logic [NUM_CHAN-1:0][POS_W-1:0]   pos;
    logic [NUM_CHAN-1:0][PAD_W-1:0]   pad;
  } cfg_t;

  // Partial remainder and dividend/quotient shift word, one pair per channel.
  typedef struct packed {
    logic [NUM_CHAN-1:0][CHAN_W-1:0] rem;
    logic [NUM_CHAN-1:0][CHAN_W-1:0] low;
  } div_word_t;

endpackage

`default_nettype wire

FILE: hdl/rgb16_brightness_scale.sv
// ----------------------------------------------------------------------------
// rgb16_brightness_scale
// Brightness fade of packed 16-bit pixels with programmable channel layout.
// ----------------------------------------------------------------------------
// Takes one pixel request per clock while the chain is not stalled and
// returns one scaled pixel per request, in order. The path is a chain of
// ten register stages: channel extraction and the 8x8 brightness multiply,
// eight division cells that each resolve one quotient bit for all three
// channels against brightness_max, and the repack/sum output register.
// Throughput is one pixel per clock while the output is not stalled; a
// stall at the output backs up through the chain. Write the configuration
// registers only while no request is in flight.
`default_nettype none

module rgb16_brightness_scale
  import rgbbs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [PIXEL_W-1:0]   pixel_in,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [PIXEL_W-1:0]        pixel_out
);

  `include "rgb16_brightness_scale_assert.svh"

  logic [CHAN_W-1:0] brightness_now;
  logic [CHAN_W-1:0] brightness_max;
  logic [POS_W-1:0]  red_position;
  logic [POS_W-1:0]  green_position;
  logic [POS_W-1:0]  blue_position;
  logic [PAD_W-1:0]  red_pad;
  logic [PAD_W-1:0]  green_pad;
  logic [PAD_W-1:0]  blue_pad;

  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness_now <= RST_BRIGHTNESS_NOW;
      brightness_max <= RST_BRIGHTNESS_MAX;
      red_position   <= RST_RED_POS;
      green_position <= RST_GREEN_POS;
      blue_position  <= RST_BLUE_POS;
      red_pad        <= RST_RED_PAD;
      green_pad      <= RST_GREEN_PAD;
      blue_pad       <= RST_BLUE_PAD;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_BRIGHTNESS_NOW: brightness_now <= cfg_data;
        REG_BRIGHTNESS_MAX: brightness_max <= cfg_data;
        REG_RED_POSITION:   red_position   <= cfg_data[POS_W-1:0];
        REG_GREEN_POSITION: green_position <= cfg_data[POS_W-1:0];
        REG_BLUE_POSITION:  blue_position  <= cfg_data[POS_W-1:0];
        REG_RED_PAD:        red_pad        <= cfg_data[PAD_W-1:0];
        REG_GREEN_PAD:      green_pad      <= cfg_data[PAD_W-1:0];
        REG_BLUE_PAD:       blue_pad       <= cfg_data[PAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the fade level to the maximum.
  always_comb begin
    cfg.level           = (brightness_now > brightness_max) ? brightness_max
                                                            : brightness_now;
    cfg.max_level       = brightness_max;
    cfg.pos[CH_RED]     = red_position;
    cfg.pos[CH_GREEN]   = green_position;
    cfg.pos[CH_BLUE]    = blue_position;
    cfg.pad[CH_RED]     = red_pad;
    cfg.pad[CH_GREEN]   = green_pad;
    cfg.pad[CH_BLUE]    = blue_pad;
  end

  logic      stage_valid [DIV_STEPS+1];
  logic      stage_ready [DIV_STEPS+1];
  div_word_t stage_word  [DIV_STEPS+1];

  rgbbs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pixel     (pixel_in),
    .out_valid (stage_valid[0]),
    .out_ready (stage_ready[0]),
    .out_word  (stage_word[0])
  );

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
    rgbbs_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .divisor   (brightness_max),
      .in_valid  (stage_valid[i]),
      .in_ready  (stage_ready[i]),
      .in_word   (stage_word[i]),
      .out_valid (stage_valid[i+1]),
      .out_ready (stage_ready[i+1]),
      .out_word  (stage_word[i+1])
    );
  end

  rgbbs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (stage_valid[DIV_STEPS]),
    .in_ready  (stage_ready[DIV_STEPS]),
    .in_word   (stage_word[DIV_STEPS]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pixel     (pixel_out)
  );

  // A refused request means the chain is full back to a stalled output.
  `RGBBS_ASSERT_NOW(a_stall_origin, !in_ready, out_valid && !out_ready)
  // An accepted request occupies the front stage on the next clock.
  `RGBBS_ASSERT_NEXT(a_front_load, in_valid && in_ready, stage_valid[0])
  // A zero maximum brightness yields a black pixel.
  `RGBBS_ASSERT_NOW(a_zero_max, out_valid && brightness_max == '0, pixel_out == '0)

endmodule

`default_nettype wire

FILE: hdl/rgbbs_front.sv
// ----------------------------------------------------------------------------
// rgbbs_front
// Channel extraction and brightness multiply, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbbs_front
  import rgbbs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cfg_t               cfg,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [PIXEL_W-1:0] pixel,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output div_word_t               out_word
);

  div_word_t word_next;

  always_comb begin
    logic [CHAN_W-1:0]   sh;
    logic [CHAN_W-1:0]   chan;
    logic [2*CHAN_W-1:0] prod;
    word_next = '0;
    for (int c = 0; c < NUM_CHAN; c++) begin
      sh   = CHAN_W'(pixel >> cfg.pos[c]);
      chan = sh << cfg.pad[c];
      prod = (2*CHAN_W)'(chan) * (2*CHAN_W)'(cfg.level);
      word_next.rem[c] = prod[2*CHAN_W-1:CHAN_W];
      word_next.low[c] = prod[CHAN_W-1:0];
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_word <= word_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/rgbbs_div_cell.sv
// ----------------------------------------------------------------------------
// rgbbs_div_cell
// One restoring-division step for all channels: one quotient bit per cell.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbbs_div_cell
  import rgbbs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [CHAN_W-1:0] divisor,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire div_word_t         in_word,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output div_word_t              out_word
);

  div_word_t word_next;

  always_comb begin
    logic [CHAN_W:0] trial;
    logic [CHAN_W:0] diff;
    logic            ge;
    word_next = '0;
    for (int c = 0; c < NUM_CHAN; c++) begin
      trial = {in_word.rem[c], in_word.low[c][CHAN_W-1]};
      diff  = trial - {1'b0, divisor};
      ge    = (trial >= {1'b0, divisor});
      word_next.rem[c] = ge ? diff[CHAN_W-1:0] : trial[CHAN_W-1:0];
      word_next.low[c] = {in_word.low[c][CHAN_W-2:0], ge};
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_word <= word_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/rgbbs_back.sv
// ----------------------------------------------------------------------------
// rgbbs_back
// Repack the scaled channels into a pixel and hold it in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbbs_back
  import rgbbs_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire cfg_t         cfg,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire div_word_t    in_word,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [PIXEL_W-1:0] pixel
);

  logic [PIXEL_W-1:0] pixel_next;

  always_comb begin
    logic [CHAN_W-1:0]  q;
    logic [PIXEL_W-1:0] term;
    pixel_next = '0;
    for (int c = 0; c < NUM_CHAN; c++) begin
      q          = in_word.low[c] >> cfg.pad[c];
      term       = PIXEL_W'(q) << cfg.pos[c];
      pixel_next = pixel_next + term;
    end
    if (cfg.max_level == '0) begin
      pixel_next = '0;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pixel <= pixel_next;
    end
  end

endmodule

`default_nettype wire

FILE: tb/sv/rgb16_brightness_scale_tb.sv
// ----------------------------------------------------------------------------
// rgb16_brightness_scale_tb
// Streams packed pixels through the brightness scaler under random input gaps
// and output stalls, and checks each scaled pixel against a local predictor
// of the per-channel extract, multiply, divide and repack. Configuration is
// changed between phases while the pipeline is empty, covering the reset
// layout, random layouts, a brightness level above the maximum, and a zero
// maximum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb16_brightness_scale_tb
  import rgbbs_pkg::*;
();

  localparam int CYCLE_LIMIT = 500000;
  localparam int TARGET_PIXELS = 1150;

  typedef struct packed {
    logic [CHAN_W-1:0]              now_level;
    logic [CHAN_W-1:0]              max_level;
    logic [NUM_CHAN-1:0][POS_W-1:0] pos;
    logic [NUM_CHAN-1:0][PAD_W-1:0] pad;
  } fade_cfg_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [PIXEL_W-1:0]   pixel_in = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [PIXEL_W-1:0]   pixel_out;

  fade_cfg_t          fade_cfg;
  logic [PIXEL_W-1:0] pixel_queue[$];
  logic [PIXEL_W-1:0] expected_pixels[$];
  int                 mismatch_count = 0;
  int                 cycle_count = 0;
  int                 send_gap = 0;
  int                 stall_left = 0;
  bit                 in_fire = 1'b0;
  bit                 quiet_in = 1'b0;
  bit                 quiet_out = 1'b0;

  rgb16_brightness_scale uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pixel_in  (pixel_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pixel_out (pixel_out)
  );

  always #5 clk = ~clk;

  function automatic logic [PIXEL_W-1:0] channel_share(logic [PIXEL_W-1:0] pix,
      logic [POS_W-1:0] pos, logic [PAD_W-1:0] pad, logic [CHAN_W-1:0] lvl,
      logic [CHAN_W-1:0] maxv);
    logic [31:0] v;
    if (maxv == 0) return '0;
    v = ((32'(pix) >> pos) << pad) & 32'hff;
    v = (v * lvl) / maxv;
    v = v >> pad;
    v = v << pos;
    return v[PIXEL_W-1:0];
  endfunction

  function automatic logic [PIXEL_W-1:0] scale_pixel(logic [PIXEL_W-1:0] pix);
    logic [CHAN_W-1:0]  lvl;
    logic [PIXEL_W-1:0] sum;
    lvl = (fade_cfg.now_level > fade_cfg.max_level) ? fade_cfg.max_level
                                                    : fade_cfg.now_level;
    sum = channel_share(pix, fade_cfg.pos[CH_RED], fade_cfg.pad[CH_RED], lvl,
                        fade_cfg.max_level)
        + channel_share(pix, fade_cfg.pos[CH_GREEN], fade_cfg.pad[CH_GREEN], lvl,
                        fade_cfg.max_level)
        + channel_share(pix, fade_cfg.pos[CH_BLUE], fade_cfg.pad[CH_BLUE], lvl,
                        fade_cfg.max_level);
    return sum;
  endfunction

  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [PIXEL_W-1:0] random_pixel();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return PIXEL_W'($urandom_range(0, 16'hffff));
    if (r < 90) return '0;
    if (r < 95) return '1;
    return PIXEL_W'(1) << $urandom_range(0, PIXEL_W - 1);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [CFG_DAT_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_BRIGHTNESS_NOW: fade_cfg.now_level = val;
      REG_BRIGHTNESS_MAX: fade_cfg.max_level = val;
      REG_RED_POSITION:   fade_cfg.pos[CH_RED] = val[POS_W-1:0];
      REG_GREEN_POSITION: fade_cfg.pos[CH_GREEN] = val[POS_W-1:0];
      REG_BLUE_POSITION:  fade_cfg.pos[CH_BLUE] = val[POS_W-1:0];
      REG_RED_PAD:        fade_cfg.pad[CH_RED] = val[PAD_W-1:0];
      REG_GREEN_PAD:      fade_cfg.pad[CH_GREEN] = val[PAD_W-1:0];
      REG_BLUE_PAD:       fade_cfg.pad[CH_BLUE] = val[PAD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_layout(input logic [7:0] rp, input logic [7:0] gp,
      input logic [7:0] bp, input logic [7:0] rd, input logic [7:0] gd,
      input logic [7:0] bd);
    write_reg(REG_RED_POSITION, rp);
    write_reg(REG_GREEN_POSITION, gp);
    write_reg(REG_BLUE_POSITION, bp);
    write_reg(REG_RED_PAD, rd);
    write_reg(REG_GREEN_PAD, gd);
    write_reg(REG_BLUE_PAD, bd);
  endtask

  task automatic wait_idle();
    while (pixel_queue.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(posedge clk);
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (in_fire) send_gap = pick_gap(quiet_in);
      if (send_gap == 0 && pixel_queue.size() > 0) begin
        pixel_in <= pixel_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
        if (send_gap > 0) send_gap--;
      end
    end
  end

  // output stalls
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      stall_left = pick_gap(quiet_out);
      out_ready <= (stall_left == 0);
    end
  end

  // monitor
  always @(posedge clk) begin
    logic [PIXEL_W-1:0] want;
    cycle_count++;
    in_fire = !rst && in_valid && in_ready;
    if (in_fire) expected_pixels.push_back(scale_pixel(pixel_in));
    if (!rst && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel_out %h", pixel_out));
      end else begin
        want = expected_pixels.pop_front();
        if (pixel_out !== want)
          report_mismatch($sformatf("pixel_out %h, expected %h", pixel_out, want));
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int sent;
    int count;
    int mode;
    fade_cfg.now_level   = RST_BRIGHTNESS_NOW;
    fade_cfg.max_level   = RST_BRIGHTNESS_MAX;
    fade_cfg.pos[CH_RED]   = RST_RED_POS;
    fade_cfg.pos[CH_GREEN] = RST_GREEN_POS;
    fade_cfg.pos[CH_BLUE]  = RST_BLUE_POS;
    fade_cfg.pad[CH_RED]   = RST_RED_PAD;
    fade_cfg.pad[CH_GREEN] = RST_GREEN_PAD;
    fade_cfg.pad[CH_BLUE]  = RST_BLUE_PAD;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset layout, full brightness
    pixel_queue = '{16'h0000, 16'hffff, 16'hf800, 16'h07e0, 16'h001f,
                    16'h8000, 16'h0001, 16'haaaa, 16'h5555};
    wait_idle();

    // level above maximum
    write_reg(REG_BRIGHTNESS_NOW, 8'd200);
    write_reg(REG_BRIGHTNESS_MAX, 8'd100);
    pixel_queue = '{16'hffff, 16'h1234};
    wait_idle();

    // zero maximum
    write_reg(REG_BRIGHTNESS_MAX, 8'd0);
    pixel_queue = '{16'hffff, 16'h7bef};
    wait_idle();

    // zero level
    write_reg(REG_BRIGHTNESS_NOW, 8'd0);
    write_reg(REG_BRIGHTNESS_MAX, 8'd255);
    pixel_queue = '{16'hffff};
    wait_idle();

    // overlapping full-width channels, carries past bit 7
    write_reg(REG_BRIGHTNESS_NOW, 8'd1);
    write_reg(REG_BRIGHTNESS_MAX, 8'd1);
    set_layout(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    pixel_queue = '{16'hffff, 16'h00ff};
    wait_idle();

    // top position, widest pad
    write_reg(REG_BRIGHTNESS_NOW, 8'd255);
    write_reg(REG_BRIGHTNESS_MAX, 8'd255);
    set_layout(8'd15, 8'd15, 8'd15, 8'd7, 8'd7, 8'd7);
    pixel_queue = '{16'h8000, 16'hffff};
    wait_idle();

    sent = 0;
    while (sent < TARGET_PIXELS) begin
      mode = $urandom_range(0, 9);
      if (mode < 5) begin
        set_layout(8'd11, 8'd5, 8'd0, 8'd3, 8'd2, 8'd3);
        write_reg(REG_BRIGHTNESS_MAX, 8'($urandom_range(1, 255)));
        write_reg(REG_BRIGHTNESS_NOW, 8'($urandom_range(0, 255)));
      end else if (mode < 8) begin
        set_layout(8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom), 8'($urandom), 8'($urandom));
        write_reg(REG_BRIGHTNESS_MAX, 8'($urandom_range(1, 255)));
        write_reg(REG_BRIGHTNESS_NOW, 8'($urandom_range(0, 255)));
      end else if (mode == 8) begin
        write_reg(REG_BRIGHTNESS_NOW, $urandom_range(0, 1) ? 8'd255 : 8'd0);
        case ($urandom_range(0, 2))
          0: write_reg(REG_BRIGHTNESS_MAX, 8'd0);
          1: write_reg(REG_BRIGHTNESS_MAX, 8'd1);
          default: write_reg(REG_BRIGHTNESS_MAX, 8'd255);
        endcase
      end else begin
        write_reg(REG_BRIGHTNESS_MAX, 8'($urandom_range(0, 127)));
        write_reg(REG_BRIGHTNESS_NOW, 8'($urandom_range(128, 255)));
      end
      quiet_in = ($urandom_range(0, 4) == 0);
      quiet_out = ($urandom_range(0, 4) == 0);
      count = $urandom_range(40, 150);
      repeat (count) pixel_queue.push_back(random_pixel());
      sent += count;
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
